### rtl/i2crb_pkg.sv
// shared types, codes and constants of the i2c target register bank
`timescale 1ns / 1ps

package i2crb_pkg;

	// default geometry
	localparam int NUM_REGS_DEF = 10;
	localparam int RX_DEPTH_DEF = 11;

	// field widths
	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 9;

	// saturation point of the read pointer
	localparam logic [IDX_W-1:0] IDX_MAX = 9'd511;

	// request codes
	localparam logic [CMD_W-1:0] CMD_WR_START = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DATA     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RD_START = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_NEXT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_END      = 3'd4;

	// led command patterns in buffer bytes one to three
	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_N = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_UPPER_U = 8'h55;
	localparam logic [BYTE_W-1:0] CH_LOWER_I = 8'h69;
	localparam logic [BYTE_W-1:0] CH_LOWER_T = 8'h74;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_COPY,
		ST_DRAIN
	} state_t;

endpackage

### rtl/i2c_target_register_bank_unit.sv
// I2C target register bank: byte-event sequencer over bank and receive buffer
// Usage:
//  - one request channel: cmd and data_in are taken at a clock edge where
//    start is high and busy is low; busy stays high while the request runs
//  - one result per request: done is high for exactly one cycle while
//    read_data, read_valid, byte_accepted, led_on and range_error hold it
//  - states that a request passes through before its done cycle:
//      write start, data byte, other codes, end with no copy: exec
//      read start, read next: exec, read (the bank read port is registered)
//      end that copies n buffered bytes into the bank: exec, copy, drain
//  - the next request may be accepted in the done cycle; the end copy
//    moves one byte a cycle through the receive buffer read port into the
//    bank write port
//  - reset clears the sequencer, the byte count, the read pointer, the led
//    level, the head bytes of the receive buffer and the bank written marks,
//    so the bank reads as zero at once; no clearing pass is needed
//  - the receiver cannot stall; each result must be taken in its done cycle
`timescale 1ns / 1ps

module i2c_target_register_bank_unit #(
	parameter int NUM_REGS = i2crb_pkg::NUM_REGS_DEF,
	parameter int RX_DEPTH = i2crb_pkg::RX_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [i2crb_pkg::CMD_W-1:0]   cmd,
	input  logic [i2crb_pkg::BYTE_W-1:0]  data_in,
	output logic                          done,
	output logic [i2crb_pkg::BYTE_W-1:0]  read_data,
	output logic                          read_valid,
	output logic                          byte_accepted,
	output logic                          led_on,
	output logic                          range_error
);

	localparam int BAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int RAW = $clog2(RX_DEPTH);
	localparam int CW  = $clog2(RX_DEPTH + 1);
	localparam int SW  = ((CW > 8) ? CW : 8) + 1;
	localparam int BW  = i2crb_pkg::BYTE_W;
	localparam int IW  = i2crb_pkg::IDX_W;

	i2crb_pkg::state_t state_q, state_d;

	logic [i2crb_pkg::CMD_W-1:0] cmd_q;
	logic [BW-1:0]               din_q;
	logic [CW-1:0]               rx_count_q;
	logic [IW-1:0]               read_index_q;
	logic                        led_q;
	logic [CW-1:0]               k_q;
	logic                        cp_vld_s1;
	logic [BAW-1:0]              cp_addr_s1;
	logic                        rd_hit_s1;
	logic                        done_q;
	logic [BW-1:0]               rdata_q;
	logic                        rvalid_q;
	logic                        acc_q;
	logic                        rerr_q;

	logic                        rx_we;
	logic                        rx_re;
	logic [RAW-1:0]              rx_raddr;
	logic [BW-1:0]               rx_rdata;
	logic [3:0][BW-1:0]          head;
	logic                        bank_re;
	logic [BAW-1:0]              bank_raddr;
	logic [BW-1:0]               bank_rdata;

	logic [CW-1:0]               n_bytes;
	logic                        over;
	logic [SW-1:0]               cp_sum;
	logic [IW-1:0]               idx_next;
	logic                        idx_in_range;
	logic                        pat_on;
	logic                        pat_off;
	logic                        res_load;
	logic                        led_upd;
	logic [BW-1:0]               res_data;
	logic                        res_valid;
	logic                        res_acc;
	logic                        res_err;

	// write extent check and copy address
	assign n_bytes = rx_count_q - CW'(1);
	assign over    = (SW'(head[0]) + SW'(n_bytes)) > SW'(NUM_REGS);
	assign cp_sum  = SW'(head[0]) + SW'(k_q);

	// read pointer update
	always_comb begin
		if (cmd_q == i2crb_pkg::CMD_RD_START) begin
			idx_next = IW'(head[0]);
		end else if (read_index_q < i2crb_pkg::IDX_MAX) begin
			idx_next = read_index_q + IW'(1);
		end else begin
			idx_next = read_index_q;
		end
	end
	assign idx_in_range = idx_next < IW'(NUM_REGS);

	// led pattern match
	assign pat_on  = (head[1] == i2crb_pkg::CH_UPPER_A) && (head[2] == i2crb_pkg::CH_LOWER_A)
		&& (head[3] == i2crb_pkg::CH_LOWER_N);
	assign pat_off = (head[1] == i2crb_pkg::CH_UPPER_U) && (head[2] == i2crb_pkg::CH_LOWER_I)
		&& (head[3] == i2crb_pkg::CH_LOWER_T);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			i2crb_pkg::ST_IDLE: begin
				if (start) begin
					state_d = i2crb_pkg::ST_EXEC;
				end
			end
			i2crb_pkg::ST_EXEC: begin
				case (cmd_q)
					i2crb_pkg::CMD_RD_START, i2crb_pkg::CMD_RD_NEXT: begin
						state_d = i2crb_pkg::ST_READ;
					end
					i2crb_pkg::CMD_END: begin
						if ((rx_count_q != '0) && !over && (n_bytes != '0)) begin
							state_d = i2crb_pkg::ST_COPY;
						end else begin
							state_d = i2crb_pkg::ST_IDLE;
						end
					end
					default: begin
						state_d = i2crb_pkg::ST_IDLE;
					end
				endcase
			end
			i2crb_pkg::ST_READ: begin
				state_d = i2crb_pkg::ST_IDLE;
			end
			i2crb_pkg::ST_COPY: begin
				if (k_q == (n_bytes - CW'(1))) begin
					state_d = i2crb_pkg::ST_DRAIN;
				end
			end
			i2crb_pkg::ST_DRAIN: begin
				state_d = i2crb_pkg::ST_IDLE;
			end
			default: begin
				state_d = i2crb_pkg::ST_IDLE;
			end
		endcase
	end

	// memory strobes and result selection
	always_comb begin
		rx_we      = 1'b0;
		rx_re      = 1'b0;
		rx_raddr   = RAW'(k_q + CW'(1));
		bank_re    = 1'b0;
		bank_raddr = idx_next[BAW-1:0];
		res_load   = 1'b0;
		led_upd    = 1'b0;
		res_data   = '0;
		res_valid  = 1'b0;
		res_acc    = 1'b0;
		res_err    = 1'b0;
		case (state_q)
			i2crb_pkg::ST_EXEC: begin
				case (cmd_q)
					i2crb_pkg::CMD_DATA: begin
						rx_we    = rx_count_q < CW'(RX_DEPTH);
						res_acc  = rx_we;
						res_load = 1'b1;
					end
					i2crb_pkg::CMD_RD_START, i2crb_pkg::CMD_RD_NEXT: begin
						bank_re = idx_in_range;
					end
					i2crb_pkg::CMD_END: begin
						if ((rx_count_q == '0) || over || (n_bytes == '0)) begin
							res_load = 1'b1;
							res_err  = (rx_count_q != '0) && over;
							led_upd  = (rx_count_q != '0) && !over;
						end
					end
					default: begin
						res_load = 1'b1;
					end
				endcase
			end
			i2crb_pkg::ST_READ: begin
				res_load  = 1'b1;
				res_valid = 1'b1;
				// an index past the bank reads as zero
				res_data  = rd_hit_s1 ? bank_rdata : '0;
			end
			i2crb_pkg::ST_COPY: begin
				rx_re = 1'b1;
			end
			i2crb_pkg::ST_DRAIN: begin
				res_load = 1'b1;
				led_upd  = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// sequencer, counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= i2crb_pkg::ST_IDLE;
			cmd_q        <= '0;
			din_q        <= '0;
			rx_count_q   <= '0;
			read_index_q <= '0;
			led_q        <= 1'b0;
			k_q          <= '0;
			cp_vld_s1    <= 1'b0;
			cp_addr_s1   <= '0;
			rd_hit_s1    <= 1'b0;
			done_q       <= 1'b0;
			rdata_q      <= '0;
			rvalid_q     <= 1'b0;
			acc_q        <= 1'b0;
			rerr_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= res_load;
			rd_hit_s1 <= bank_re;
			if ((state_q == i2crb_pkg::ST_IDLE) && start) begin
				cmd_q <= cmd;
				din_q <= data_in;
			end
			if ((state_q == i2crb_pkg::ST_EXEC) && (cmd_q == i2crb_pkg::CMD_WR_START)) begin
				rx_count_q <= '0;
			end else if (rx_we) begin
				rx_count_q <= rx_count_q + CW'(1);
			end
			if ((state_q == i2crb_pkg::ST_EXEC) && ((cmd_q == i2crb_pkg::CMD_RD_START)
					|| (cmd_q == i2crb_pkg::CMD_RD_NEXT))) begin
				read_index_q <= idx_next;
			end
			// copy pipeline: buffer read in one cycle, bank write in the next
			if (state_q == i2crb_pkg::ST_COPY) begin
				k_q <= k_q + CW'(1);
			end else begin
				k_q <= '0;
			end
			cp_vld_s1  <= rx_re;
			cp_addr_s1 <= cp_sum[BAW-1:0];
			if (led_upd) begin
				if (pat_on) begin
					led_q <= 1'b1;
				end else if (pat_off) begin
					led_q <= 1'b0;
				end
			end
			if (res_load) begin
				rdata_q  <= res_data;
				rvalid_q <= res_valid;
				acc_q    <= res_acc;
				rerr_q   <= res_err;
			end
		end
	end

	// receive buffer
	i2crb_rxbuf #(
		.RX_DEPTH (RX_DEPTH),
		.AW       (RAW)
	) u_rxbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (rx_we),
		.waddr  (rx_count_q[RAW-1:0]),
		.wdata  (din_q),
		.re     (rx_re),
		.raddr  (rx_raddr),
		.rdata  (rx_rdata),
		.head   (head)
	);

	// register bank
	i2crb_bank #(
		.NUM_REGS (NUM_REGS),
		.AW       (BAW)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cp_vld_s1),
		.waddr  (cp_addr_s1),
		.wdata  (rx_rdata),
		.re     (bank_re),
		.raddr  (bank_raddr),
		.rdata  (bank_rdata)
	);

	// ports
	assign busy          = state_q != i2crb_pkg::ST_IDLE;
	assign done          = done_q;
	assign read_data     = rdata_q;
	assign read_valid    = rvalid_q;
	assign byte_accepted = acc_q;
	assign led_on        = led_q;
	assign range_error   = rerr_q;

endmodule

### rtl/i2crb_bank.sv
// register bank memory with per-entry valid bits standing in for reset
`timescale 1ns / 1ps

module i2crb_bank #(
	parameter int NUM_REGS = i2crb_pkg::NUM_REGS_DEF,
	parameter int AW       = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [i2crb_pkg::BYTE_W-1:0]  wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [i2crb_pkg::BYTE_W-1:0]  rdata
);

	logic [i2crb_pkg::BYTE_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0]          valid_q;
	logic [i2crb_pkg::BYTE_W-1:0] rdata_q;
	logic                         rvalid_q;

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	// an entry never written reads as zero
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

### rtl/i2crb_rxbuf.sv
// receive buffer memory with the first four bytes mirrored in flops
`timescale 1ns / 1ps

module i2crb_rxbuf #(
	parameter int RX_DEPTH = i2crb_pkg::RX_DEPTH_DEF,
	parameter int AW       = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic [i2crb_pkg::BYTE_W-1:0]      wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic [i2crb_pkg::BYTE_W-1:0]      rdata,
	output logic [3:0][i2crb_pkg::BYTE_W-1:0] head
);

	logic [i2crb_pkg::BYTE_W-1:0] mem [RX_DEPTH];

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	// start byte and pattern bytes, zero from reset and kept across requests
	for (genvar i = 0; i < 4; i++) begin : g_head
		if (i < RX_DEPTH) begin : g_live
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					head[i] <= '0;
				end else if (we && (waddr == AW'(i))) begin
					head[i] <= wdata;
				end
			end
		end else begin : g_none
			assign head[i] = '0;
		end
	end

endmodule

### rtl/i2crb_chk.sv
// port-level checks of the i2c target register bank, bound to the top level
`timescale 1ns / 1ps

module i2crb_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [i2crb_pkg::BYTE_W-1:0]  read_data,
	input logic                          read_valid,
	input logic                          byte_accepted,
	input logic                          led_on,
	input logic                          range_error
);

	// an accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// two results never come in consecutive cycles
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a result carries at most one kind of outcome
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones({read_valid, byte_accepted, range_error}) <= 1))
		else $error("result mixes read, accept and range error");

	// non-read results carry zero data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && !read_valid |-> (read_data == '0))
		else $error("read data not zero on a non-read result");

	// the led only moves together with a result
	a_led_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(led_on) |-> done)
		else $error("led level changed outside a result");

endmodule

bind i2c_target_register_bank_unit i2crb_chk u_chk (.*);
